FILE: rtl/core/lce_pkg.sv
// Shared constants, register indexes and the exponent table of the logistic curve evaluator.
package lce_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWER_LEVEL  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UPPER_LEVEL  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_POINT = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOPE_FACTOR = 4'd3;

   localparam int LOG2E_Q16 = 94548;
   localparam int TAB_BITS  = 18;

   // 2^(i/16) in Q16
   function automatic logic [TAB_BITS-1:0] pow2_frac(input logic [4:0] idx);
      logic [TAB_BITS-1:0] val;
      unique case (idx)
         5'd0:  val = 18'd65536;
         5'd1:  val = 18'd68438;
         5'd2:  val = 18'd71468;
         5'd3:  val = 18'd74632;
         5'd4:  val = 18'd77936;
         5'd5:  val = 18'd81386;
         5'd6:  val = 18'd84990;
         5'd7:  val = 18'd88752;
         5'd8:  val = 18'd92682;
         5'd9:  val = 18'd96785;
         5'd10: val = 18'd101070;
         5'd11: val = 18'd105545;
         5'd12: val = 18'd110217;
         5'd13: val = 18'd115097;
         5'd14: val = 18'd120193;
         5'd15: val = 18'd125515;
         default: val = 18'd131072;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/core/logistic_curve_evaluator.sv
// Top level of the four-parameter logistic curve evaluator with fit residual.
// Depth: FRAC_BITS + 12 register stages, and each request passes through all of them in order
// before rsp_valid rises (FRAC_BITS is 16 in the default Q16.16 format).
// Throughput: one request per cycle unless stalled; the divider holds FRAC_BITS + 1 stages.
// Each stage holds only while its successor is full and stalled.
// Reset clears all valid bits and loads lower 0, upper 1.0, center 0, slope 1.0.
module logistic_curve_evaluator #(
   parameter int WORD_BITS = lce_pkg::WORD_BITS_DEFAULT,
   parameter int FRAC_BITS = lce_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [WORD_BITS-1:0]         req_position,
   input  logic signed [WORD_BITS-1:0]         req_measured,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [WORD_BITS-1:0]         rsp_curve_value,
   output logic signed [WORD_BITS-1:0]         rsp_residual,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lce_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [WORD_BITS-1:0]                csr_data
);

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int Q1B = 2 * W - F;
   localparam int LB  = Q1B / 2;
   localparam int HB  = Q1B - LB;
   localparam int PB  = Q1B + W;
   localparam int XB  = F + 6;
   localparam int YB  = F + 6;
   localparam int TB  = lce_pkg::TAB_BITS;
   localparam int RB  = F - 4;
   localparam int DEN = F + 34;
   localparam int SB  = W + 2;
   localparam int Q   = F + 1;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   // configuration
   logic signed [W-1:0] lower_ff, upper_ff, center_ff, slope_ff;
   logic [W-1:0]        absdiff_ff, absphi_ff;
   logic                diff_neg_ff, diff_nz_ff, phi_neg_ff;
   logic signed [W:0]   diff_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff  <= '0;
         upper_ff  <= W'(1) << F;
         center_ff <= '0;
         slope_ff  <= W'(1) << F;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lce_pkg::REG_LOWER_LEVEL:  lower_ff  <= csr_data;
            lce_pkg::REG_UPPER_LEVEL:  upper_ff  <= csr_data;
            lce_pkg::REG_CENTER_POINT: center_ff <= csr_data;
            lce_pkg::REG_SLOPE_FACTOR: slope_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign diff_in = $signed({upper_ff[W-1], upper_ff}) - $signed({lower_ff[W-1], lower_ff});

   always_ff @(posedge clock) begin
      absdiff_ff  <= diff_in[W] ? W'(-diff_in) : W'(diff_in);
      diff_neg_ff <= diff_in[W];
      diff_nz_ff  <= diff_in != '0;
      absphi_ff   <= slope_ff[W-1] ? W'(-$signed({slope_ff[W-1], slope_ff})) : slope_ff;
      phi_neg_ff  <= slope_ff[W-1];
   end

   // flow control
   logic [8:1] pv_ff, pv_in, ptake;
   logic       div_take, div_valid;
   logic       va_ff, vb_ff, vc_ff;
   logic       take_a, take_b, take_c;

   assign take_c = !vc_ff || !rsp_stall;
   assign take_b = !vb_ff || take_c;
   assign take_a = !va_ff || take_b;

   always_comb begin
      ptake[8] = !pv_ff[8] || div_take;
      for (int k = 7; k >= 1; k--) begin
         ptake[k] = !pv_ff[k] || ptake[k+1];
      end
   end

   assign pv_in     = {pv_ff[7:1], req_valid};
   assign req_stall = !ptake[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         for (int k = 1; k <= 8; k++) begin
            if (ptake[k]) begin
               pv_ff[k] <= pv_in[k];
            end
         end
         if (take_a) begin
            va_ff <= div_valid;
         end
         if (take_b) begin
            vb_ff <= va_ff;
         end
         if (take_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   // stage 1: capture
   logic signed [W-1:0] t1_ff, y1_ff;
   always_ff @(posedge clock) begin
      if (ptake[1]) begin
         t1_ff <= req_position;
         y1_ff <= req_measured;
      end
   end

   // stage 2: distance to center
   logic signed [W:0] dd_in;
   logic [W-1:0]      absd2_ff;
   logic              negd2_ff;
   logic signed [W-1:0] y2_ff;
   assign dd_in = $signed({center_ff[W-1], center_ff}) - $signed({t1_ff[W-1], t1_ff});
   always_ff @(posedge clock) begin
      if (ptake[2]) begin
         absd2_ff <= dd_in[W] ? W'(-dd_in) : W'(dd_in);
         negd2_ff <= dd_in[W];
         y2_ff    <= y1_ff;
      end
   end

   // stage 3: distance times slope
   logic [2*W-1:0]      prod3_ff;
   logic                neg3_ff;
   logic signed [W-1:0] y3_ff;
   always_ff @(posedge clock) begin
      if (ptake[3]) begin
         prod3_ff <= absd2_ff * absphi_ff;
         neg3_ff  <= negd2_ff ^ phi_neg_ff ^ diff_neg_ff;
         y3_ff    <= y2_ff;
      end
   end

   // stage 4: times level span, split into two partial products
   logic [Q1B-1:0]      q1_in;
   logic [LB+W-1:0]     pl4_ff;
   logic [HB+W-1:0]     ph4_ff;
   logic                neg4_ff;
   logic signed [W-1:0] y4_ff;
   assign q1_in = prod3_ff[2*W-1:F];
   always_ff @(posedge clock) begin
      if (ptake[4]) begin
         pl4_ff  <= q1_in[LB-1:0] * absdiff_ff;
         ph4_ff  <= q1_in[Q1B-1:LB] * absdiff_ff;
         neg4_ff <= neg3_ff;
         y4_ff   <= y3_ff;
      end
   end

   // stage 5: exponent argument and clamp
   logic [PB-1:0]        p5_in;
   logic [PB-F-1:0]      xm_in;
   logic signed [XB-1:0] x5_ff;
   logic                 clamp5_ff, neg5_ff;
   logic signed [W-1:0]  y5_ff;
   assign p5_in = (PB'(ph4_ff) << LB) + PB'(pl4_ff);
   assign xm_in = p5_in[PB-1:F];
   always_ff @(posedge clock) begin
      if (ptake[5]) begin
         x5_ff     <= neg4_ff ? -$signed(XB'(xm_in)) : $signed(XB'(xm_in));
         clamp5_ff <= xm_in > (PB-F)'(32'd16 << F);
         neg5_ff   <= neg4_ff;
         y5_ff     <= y4_ff;
      end
   end

   // stage 6: scale by log2(e), bias positive
   logic signed [XB+17:0] xl_in, ys_in;
   logic [YB-1:0]         yq6_ff;
   logic                  clamp6_ff, neg6_ff;
   logic signed [W-1:0]   y6_ff;
   assign xl_in = x5_ff * $signed(18'(lce_pkg::LOG2E_Q16));
   assign ys_in = (xl_in >>> 16) + (XB+18)'(32'd32 << F);
   always_ff @(posedge clock) begin
      if (ptake[6]) begin
         yq6_ff    <= YB'(ys_in);
         clamp6_ff <= clamp5_ff;
         neg6_ff   <= neg5_ff;
         y6_ff     <= y5_ff;
      end
   end

   // stage 7: table lookup and interpolation product
   logic [3:0]          idx_in;
   logic [TB-1:0]       dt_in;
   logic [TB-1:0]       a7_ff;
   logic [TB+RB-1:0]    pr7_ff;
   logic [5:0]          n7_ff;
   logic                clamp7_ff, neg7_ff;
   logic signed [W-1:0] y7_ff;
   assign idx_in = yq6_ff[F-1 -: 4];
   assign dt_in  = lce_pkg::pow2_frac(5'(idx_in) + 5'd1) - lce_pkg::pow2_frac(5'(idx_in));
   always_ff @(posedge clock) begin
      if (ptake[7]) begin
         a7_ff     <= lce_pkg::pow2_frac(5'(idx_in));
         pr7_ff    <= dt_in * yq6_ff[RB-1:0];
         n7_ff     <= yq6_ff[YB-1:F];
         clamp7_ff <= clamp6_ff;
         neg7_ff   <= neg6_ff;
         y7_ff     <= y6_ff;
      end
   end

   // stage 8: mantissa shift, denominator
   logic [TB-1:0]       m_in;
   logic signed [7:0]   sh_in;
   logic [DEN-1:0]      e_in;
   logic [DEN-1:0]      den8_ff;
   logic                clamp8_ff, neg8_ff;
   logic signed [W-1:0] y8_ff;
   assign m_in  = a7_ff + TB'(pr7_ff >> RB);
   assign sh_in = $signed({2'b00, n7_ff}) + $signed(8'(F)) - 8'sd48;
   assign e_in  = !sh_in[7] ? (DEN'(m_in) << sh_in[6:0]) : (DEN'(m_in) >> 7'(-sh_in));
   always_ff @(posedge clock) begin
      if (ptake[8]) begin
         den8_ff   <= (DEN'(1) << F) + e_in;
         clamp8_ff <= clamp7_ff;
         neg8_ff   <= neg7_ff;
         y8_ff     <= y7_ff;
      end
   end

   // divider
   logic [Q-1:0]  div_quo;
   logic [SB-1:0] div_side;

   lce_divider #(
      .FRAC_BITS (F),
      .DEN_BITS  (DEN),
      .SIDE_BITS (SB)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pv_ff[8]),
      .in_take   (div_take),
      .in_den    (den8_ff),
      .in_side   ({y8_ff, clamp8_ff, neg8_ff}),
      .out_valid (div_valid),
      .out_take  (take_a),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // stage A: span times sigmoid
   logic [W+Q-1:0]      proda_ff;
   logic                clampa_ff, nega_ff;
   logic signed [W-1:0] ya_ff;
   always_ff @(posedge clock) begin
      if (take_a) begin
         proda_ff  <= absdiff_ff * div_quo;
         clampa_ff <= div_side[1];
         nega_ff   <= div_side[0];
         ya_ff     <= div_side[SB-1:2];
      end
   end

   // stage B: curve value
   logic [W:0]            om_in;
   logic signed [W+1:0]   off_in, sum_in;
   logic signed [W-1:0]   vsat_in;
   logic signed [W-1:0]   vb_val_ff, yb_ff;
   assign om_in  = proda_ff[W+F:F];
   assign off_in = diff_neg_ff ? -$signed({1'b0, om_in}) : $signed({1'b0, om_in});
   assign sum_in = $signed({{2{lower_ff[W-1]}}, lower_ff}) + off_in;

   always_comb begin
      if (sum_in[W+1:W-1] == 3'b000 || sum_in[W+1:W-1] == 3'b111) begin
         vsat_in = W'(sum_in);
      end else if (sum_in[W+1]) begin
         vsat_in = WMIN;
      end else begin
         vsat_in = WMAX;
      end
   end

   always_ff @(posedge clock) begin
      if (take_b) begin
         if (clampa_ff) begin
            vb_val_ff <= nega_ff ? upper_ff : lower_ff;
         end else begin
            vb_val_ff <= vsat_in;
         end
         yb_ff <= ya_ff;
      end
   end

   // stage C: residual, output register
   logic signed [W:0]   r_in;
   logic signed [W-1:0] value_ff, residual_ff;
   assign r_in = $signed({yb_ff[W-1], yb_ff}) - $signed({vb_val_ff[W-1], vb_val_ff});
   always_ff @(posedge clock) begin
      if (take_c) begin
         value_ff <= vb_val_ff;
         if (r_in[W] != r_in[W-1]) begin
            residual_ff <= r_in[W] ? WMIN : WMAX;
         end else begin
            residual_ff <= W'(r_in);
         end
      end
   end

   assign rsp_valid       = vc_ff;
   assign rsp_curve_value = value_ff;
   assign rsp_residual    = residual_ff;

   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without output backpressure");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_sigmoid_bound: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> (div_quo <= (Q'(1) << F)))
      else $error("sigmoid quotient above one");

endmodule

FILE: rtl/core/lce_divider.sv
// Pipelined restoring divider: rounded 2^(2F) / den, one quotient bit per stage.
module lce_divider #(
   parameter int FRAC_BITS = lce_pkg::FRAC_BITS_DEFAULT,
   parameter int DEN_BITS  = lce_pkg::FRAC_BITS_DEFAULT + 34,
   parameter int SIDE_BITS = lce_pkg::WORD_BITS_DEFAULT + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_take,
   input  logic [DEN_BITS-1:0]  in_den,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   input  logic                 out_take,
   output logic [FRAC_BITS:0]   out_quo,
   output logic [SIDE_BITS-1:0] out_side
);

   localparam int Q  = FRAC_BITS + 1;
   localparam int RW = DEN_BITS + FRAC_BITS + 1;

   logic [Q-1:0]         v_ff;
   logic [Q:0]           take;
   logic [RW-1:0]        rem_ff  [Q];
   logic [DEN_BITS-1:0]  den_ff  [Q];
   logic [Q-1:0]         quo_ff  [Q];
   logic [SIDE_BITS-1:0] side_ff [Q];

   logic [RW-1:0]        rem_in  [Q];
   logic [Q-1:0]         quo_in  [Q];
   logic [DEN_BITS-1:0]  den_src [Q];
   logic [SIDE_BITS-1:0] side_src[Q];
   logic [Q-1:0]         v_src;

   always_comb begin
      take[Q] = out_take;
      for (int j = Q - 1; j >= 0; j--) begin
         take[j] = !v_ff[j] || take[j+1];
      end
   end

   always_comb begin
      logic [RW-1:0] rem_src;
      logic [Q-1:0]  quo_src;
      logic [RW-1:0] shifted;
      for (int j = 0; j < Q; j++) begin
         if (j == 0) begin
            rem_src     = (RW'(1) << (2 * FRAC_BITS)) + RW'(in_den >> 1);
            quo_src     = '0;
            den_src[j]  = in_den;
            side_src[j] = in_side;
            v_src[j]    = in_valid;
         end else begin
            rem_src     = rem_ff[j-1];
            quo_src     = quo_ff[j-1];
            den_src[j]  = den_ff[j-1];
            side_src[j] = side_ff[j-1];
            v_src[j]    = v_ff[j-1];
         end
         shifted = RW'(den_src[j]) << (Q - 1 - j);
         if (rem_src >= shifted) begin
            rem_in[j] = rem_src - shifted;
            quo_in[j] = quo_src | (Q'(1) << (Q - 1 - j));
         end else begin
            rem_in[j] = rem_src;
            quo_in[j] = quo_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int j = 0; j < Q; j++) begin
            if (take[j]) begin
               v_ff[j] <= v_src[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < Q; j++) begin
         if (take[j]) begin
            rem_ff[j]  <= rem_in[j];
            quo_ff[j]  <= quo_in[j];
            den_ff[j]  <= den_src[j];
            side_ff[j] <= side_src[j];
         end
      end
   end

   assign in_take   = take[0];
   assign out_valid = v_ff[Q-1];
   assign out_quo   = quo_ff[Q-1];
   assign out_side  = side_ff[Q-1];

endmodule
